// ===== sv/hsbd_pkg.sv =====
// hsbd_pkg: shared types and constants for the histogram shot boundary detector
// no dependencies; imported by the top level

package hsbd_pkg;

	// histogram geometry: one 8-bit bin code per pixel
	localparam int BIN_BITS  = 8;
	localparam int BIN_COUNT = 256;

	// threshold register: unsigned q1.16, 65536 is 1.0
	localparam int          THRESH_W     = 17;
	localparam int          FRAC_W       = 16;
	localparam logic [16:0] THRESH_RESET = 17'd32768;

	// fixed result field widths
	localparam int OUT_CNT_W = 22;
	localparam int FRAME_W   = 32;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INC,
		ST_WALK,
		ST_DRAIN,
		ST_CMP
	} hsbd_state_t;

endpackage

// ===== sv/histogram_shot_boundary_detector.sv =====
// histogram_shot_boundary_detector: 256-bin color histogram per frame, intersection
// with the previous frame's histogram at frame end, threshold compare for shot borders
// depends on hsbd_pkg
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  pixel   | in        | in_valid / in_stall  | blue, green, red, frame_end
//  result  | out       | out_valid / out_stall| shot_border, overlap_count,
//          |           |                      | frame_pixels, frame_number
//  config  | in        | cfg_write_en         | cfg_write_data (threshold_fraction)
//
// a pixel reads its bin, then writes the incremented count back before the next pixel is taken
// a frame-end pixel does its bin update, then the walk over both histogram banks
// through the shared min/accumulate unit, then a drain state and a compare state
// the compare state waits while a previous result is still held on the output
// after reset the block zeroes every bin of both banks with in_stall high
// the two banks swap roles at each frame end, the old previous bank is zeroed on the walk

module histogram_shot_boundary_detector
	import hsbd_pkg::*;
#(
	parameter int COUNT_BITS = 22
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_write_en,
	input  logic [THRESH_W-1:0]   cfg_write_data,
	// pixel beat
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            blue,
	input  logic [7:0]            green,
	input  logic [7:0]            red,
	input  logic                  frame_end,
	// result beat
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  shot_border,
	output logic [OUT_CNT_W-1:0]  overlap_count,
	output logic [OUT_CNT_W-1:0]  frame_pixels,
	output logic [FRAME_W-1:0]    frame_number
);

	localparam int PROD_W = THRESH_W + COUNT_BITS;
	localparam int CMP_W  = COUNT_BITS + FRAC_W + 1;

	typedef logic [COUNT_BITS-1:0] cnt_t;

	hsbd_state_t state_q, state_d;

	// histogram banks
	cnt_t bank0_mem [BIN_COUNT];
	cnt_t bank1_mem [BIN_COUNT];
	cnt_t rd0_q, rd1_q;

	logic [BIN_BITS-1:0] idx_q;
	logic [BIN_BITS-1:0] bin_q;
	logic                last_q;
	logic                sel_q;
	logic                have_prev_q;
	cnt_t                pix_q;
	logic [FRAME_W-1:0]  frame_q;
	logic [THRESH_W-1:0] thr_q;
	logic                walk_v_s1;
	cnt_t                acc_q;
	logic [PROD_W-1:0]   prod_s1;

	logic                 out_valid_q;
	logic                 border_q;
	logic [OUT_CNT_W-1:0] ovl_out_q;
	logic [OUT_CNT_W-1:0] pix_out_q;
	logic [FRAME_W-1:0]   frame_out_q;

	// sequencer controls
	logic                in_accept;
	logic                wr_all, wr_cur, wr_prev;
	logic                walk_go, load_out, frame_done;
	logic                bank0_we, bank1_we;
	logic [BIN_BITS-1:0] wr_addr, rd_addr, in_bin;
	cnt_t                wr_data;

	// shared datapath
	cnt_t                cur_rd, prev_rd, cur_inc, pix_inc, min_val, acc_d;
	logic [COUNT_BITS:0] acc_sum;
	logic [CMP_W-1:0]    ovl_shift;
	logic                border_d;
	logic [31:0]         acc_ext, pix_ext;

	// bin code: blue[7:6], green[7:5], red[7:5]
	assign in_bin    = {blue[7:6], green[7:5], red[7:5]};
	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);

	assign cur_rd  = sel_q ? rd1_q : rd0_q;
	assign prev_rd = sel_q ? rd0_q : rd1_q;

	// saturating increments
	assign cur_inc = (&cur_rd) ? cur_rd : cur_rd + 1'b1;
	assign pix_inc = (&pix_q) ? pix_q : pix_q + 1'b1;

	// min and saturating accumulate
	assign min_val = (prev_rd < cur_rd) ? prev_rd : cur_rd;
	assign acc_sum = {1'b0, acc_q} + {1'b0, min_val};
	assign acc_d   = acc_sum[COUNT_BITS] ? '1 : acc_sum[COUNT_BITS-1:0];

	// overlap * 65536 against threshold * pixels
	assign ovl_shift = {1'b0, acc_q, {FRAC_W{1'b0}}};
	assign border_d  = CMP_W'(ovl_shift) < CMP_W'(prod_s1);
	assign acc_ext   = 32'(acc_q);
	assign pix_ext   = 32'(pix_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d    = state_q;
		wr_all     = 1'b0;
		wr_cur     = 1'b0;
		wr_prev    = 1'b0;
		walk_go    = 1'b0;
		load_out   = 1'b0;
		frame_done = 1'b0;
		rd_addr    = idx_q;
		case (state_q)
			ST_CLEAR: begin
				wr_all = 1'b1;
				if (idx_q == BIN_BITS'(BIN_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				rd_addr = in_bin;
				if (in_accept) begin
					state_d = ST_INC;
				end
			end
			ST_INC: begin
				wr_cur = 1'b1;
				if (last_q) begin
					walk_go = 1'b1;
					state_d = ST_WALK;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WALK: begin
				wr_prev = 1'b1;
				if (idx_q == BIN_BITS'(BIN_COUNT - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (!have_prev_q) begin
					frame_done = 1'b1;
					state_d    = ST_IDLE;
				end else if (!(out_valid_q && out_stall)) begin
					load_out   = 1'b1;
					frame_done = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// bank write port steering
	assign bank0_we = wr_all || (wr_cur && !sel_q) || (wr_prev && sel_q);
	assign bank1_we = wr_all || (wr_cur && sel_q) || (wr_prev && !sel_q);
	assign wr_addr  = wr_cur ? bin_q : idx_q;
	assign wr_data  = wr_cur ? cur_inc : '0;

	// histogram memories, registered read
	always_ff @(posedge clk) begin
		if (bank0_we) begin
			bank0_mem[wr_addr] <= wr_data;
		end
		rd0_q <= bank0_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (bank1_we) begin
			bank1_mem[wr_addr] <= wr_data;
		end
		rd1_q <= bank1_mem[rd_addr];
	end

	// sweep counter for clear and walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (state_q == ST_CLEAR || state_q == ST_WALK) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RESET;
		end else if (cfg_write_en) begin
			thr_q <= cfg_write_data;
		end
	end

	// per-frame control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= 1'b0;
			sel_q       <= 1'b0;
			have_prev_q <= 1'b0;
			pix_q       <= '0;
			frame_q     <= '0;
			walk_v_s1   <= 1'b0;
		end else begin
			walk_v_s1 <= (state_q == ST_WALK);
			if (in_accept) begin
				last_q <= frame_end;
				pix_q  <= pix_inc;
			end
			if (walk_go) begin
				frame_q <= frame_q + 1'b1;
			end
			if (frame_done) begin
				sel_q       <= !sel_q;
				have_prev_q <= 1'b1;
				pix_q       <= '0;
			end
		end
	end

	// pixel bin, overlap accumulator and threshold product
	always_ff @(posedge clk) begin
		if (in_accept) begin
			bin_q <= in_bin;
		end
		if (walk_go) begin
			acc_q <= '0;
		end else if (walk_v_s1) begin
			acc_q <= acc_d;
		end
		if (state_q == ST_DRAIN) begin
			prod_s1 <= PROD_W'(thr_q) * PROD_W'(pix_q);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			border_q    <= border_d;
			ovl_out_q   <= acc_ext[OUT_CNT_W-1:0];
			pix_out_q   <= pix_ext[OUT_CNT_W-1:0];
			frame_out_q <= frame_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign shot_border   = border_q;
	assign overlap_count = ovl_out_q;
	assign frame_pixels  = pix_out_q;
	assign frame_number  = frame_out_q;

endmodule

// ===== sv/hsbd_checker.sv =====
// hsbd_port_checks: port-level assertions for the shot boundary detector
// depends on hsbd_pkg; bound to histogram_shot_boundary_detector below

module hsbd_port_checks
	import hsbd_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic                 shot_border,
	input logic [OUT_CNT_W-1:0] overlap_count,
	input logic [OUT_CNT_W-1:0] frame_pixels,
	input logic [FRAME_W-1:0]   frame_number
);

	// clearing pass holds off pixels when reset is released
	a_clear_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> in_stall)
		else $error("pixel input open at reset release");

	// every accepted pixel beat keeps in_stall high while its read-modify-write finishes
	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("pixel accepted back to back");

	// a result appears only at the end of a frame-end sequence
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised while block was idle");

	// a stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(shot_border)
			&& $stable(overlap_count) && $stable(frame_pixels)
			&& $stable(frame_number)))
		else $error("stalled result beat changed");

endmodule

bind histogram_shot_boundary_detector hsbd_port_checks u_hsbd_port_checks (.*);
